### rtl/core/pfc_pkg.sv
// Shared types, constants and helpers for the Playfair digraph cipher.
// Depends on nothing; every module of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package pfc_pkg;

  // Geometry of the key square.
  localparam int SIDE       = 5;
  localparam int CELL_COUNT = SIDE * SIDE;
  localparam int LETTER_W   = 5;
  localparam int POS_W      = 3;
  localparam int INDEX_W    = 5;

  // Configuration register widths and reset values.
  localparam int SQUARE_W   = 60;
  localparam logic [SQUARE_W-1:0] SQUARE_LOW_RESET  = 60'd445091350149433376;
  localparam logic [SQUARE_W-1:0] SQUARE_MID_RESET  = 60'd891384680460860877;
  localparam logic [LETTER_W-1:0] SQUARE_LAST_RESET = 5'd25;

  // Configuration register indexes.
  localparam int REG_INDEX_W = 2;
  localparam logic [REG_INDEX_W-1:0] REG_SQUARE_LOW  = 2'd0;
  localparam logic [REG_INDEX_W-1:0] REG_SQUARE_MID  = 2'd1;
  localparam logic [REG_INDEX_W-1:0] REG_SQUARE_LAST = 2'd2;

  // Letter codes.
  localparam logic [LETTER_W-1:0] LETTER_I = 5'd8;
  localparam logic [LETTER_W-1:0] LETTER_J = 5'd9;

  // Action codes.
  localparam logic ACTION_ENCRYPT = 1'b0;
  localparam logic ACTION_DECRYPT = 1'b1;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [CELL_COUNT-1:0][LETTER_W-1:0] square_t;

  // Result of one lane's search through the square.
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } loc_t;

  // One step along a row or column, wrapping; decrypt steps backward.
  function automatic logic [POS_W-1:0] wrap_step(logic [POS_W-1:0] pos, logic action);
    logic [POS_W-1:0] res;
    if (action == ACTION_DECRYPT) begin
      res = (pos == '0) ? POS_W'(SIDE - 1) : pos - 1'b1;
    end else begin
      res = (pos == POS_W'(SIDE - 1)) ? '0 : pos + 1'b1;
    end
    return res;
  endfunction

  // Row-major cell index of a row and column.
  function automatic logic [INDEX_W-1:0] cell_index(logic [POS_W-1:0] row,
                                                   logic [POS_W-1:0] col);
    logic [INDEX_W-1:0] base;
    base = INDEX_W'(row) * INDEX_W'(SIDE);
    return base + INDEX_W'(col);
  endfunction

endpackage

`default_nettype wire

### rtl/core/pfc_locate.sv
// Search lane: finds the lowest key square cell that holds one letter.
// Depends on pfc_pkg for the square and location types.
`timescale 1ns / 1ps
`default_nettype none

module pfc_locate
  import pfc_pkg::*;
(
  input  wire letter_t letter,
  input  wire square_t square,
  output loc_t         loc
);

  letter_t key;

  // J shares the cell of I.
  assign key = (letter == LETTER_J) ? LETTER_I : letter;

  // Compare against every cell at once; the lowest matching cell wins.
  always_comb begin
    loc = '0;
    for (int k = CELL_COUNT - 1; k >= 0; k--) begin
      if (square[k] == key) begin
        loc.found = 1'b1;
        loc.row   = POS_W'(k / SIDE);
        loc.col   = POS_W'(k % SIDE);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/pfc_merge.sv
// Merge stage: applies the Playfair rules to the two lane locations
// and reads the chosen cells. Depends on pfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfc_merge
  import pfc_pkg::*;
(
  input  wire loc_t    loc_a,
  input  wire loc_t    loc_b,
  input  wire          action,
  input  wire square_t square,
  output letter_t      first_out,
  output letter_t      second_out,
  output logic         not_found
);

  logic               same_row;
  logic               same_col;
  logic [POS_W-1:0]   row_a;
  logic [POS_W-1:0]   col_a;
  logic [POS_W-1:0]   row_b;
  logic [POS_W-1:0]   col_b;
  logic [INDEX_W-1:0] idx_a;
  logic [INDEX_W-1:0] idx_b;

  assign same_row = (loc_a.row == loc_b.row);
  assign same_col = (loc_a.col == loc_b.col);

  // Pick the target row and column of each letter.
  always_comb begin
    row_a = loc_a.row;
    col_a = loc_a.col;
    row_b = loc_b.row;
    col_b = loc_b.col;
    if (same_row) begin
      col_a = wrap_step(loc_a.col, action);
      col_b = wrap_step(loc_b.col, action);
    end else if (same_col) begin
      row_a = wrap_step(loc_a.row, action);
      row_b = wrap_step(loc_b.row, action);
    end else begin
      col_a = loc_b.col;
      col_b = loc_a.col;
    end
  end

  assign idx_a = cell_index(row_a, col_a);
  assign idx_b = cell_index(row_b, col_b);

  // A missing letter forces both outputs to zero.
  assign not_found  = !(loc_a.found && loc_b.found);
  assign first_out  = not_found ? '0 : square[idx_a];
  assign second_out = not_found ? '0 : square[idx_b];

endmodule

`default_nettype wire

### rtl/core/playfair_digraph_cipher.sv
// Top level of the Playfair digraph cipher: configuration registers,
// two search lanes, merge stage and output register. Depends on pfc_pkg,
// pfc_locate and pfc_merge.
//
//  Channel   Direction  Contents (lowest bit first)
//  s_axis    in         tdata: first_letter[4:0], second_letter[9:5]; tuser: action
//  m_axis    out        tdata: first_out[4:0], second_out[9:5]; tuser: not_found
//  cfg       in         cfg_index selects square_low, square_mid, square_last
//
// One digraph per cycle while the output is not stalled; each passes through
// the lane search register, then the merge and output register.
// Synchronous reset clears both stage valids and loads the default square.
// A stalled output holds its stage; the lane stage still takes a new
// transaction while it is empty, so input ready drops only when both are full.
`timescale 1ns / 1ps
`default_nettype none

module playfair_digraph_cipher
  import pfc_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst,
  // Slave stream: first_letter, second_letter (low bits first).
  input  wire                    s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire  [IN_DATA_W-1:0]   s_axis_tdata,
  // Slave stream: action.
  input  wire                    s_axis_tuser,
  // Master stream: first_out, second_out (low bits first).
  output logic                   m_axis_tvalid,
  input  wire                    m_axis_tready,
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,
  // Master stream: not_found.
  output logic                   m_axis_tuser,
  // Configuration write port.
  input  wire                    cfg_wen,
  input  wire  [REG_INDEX_W-1:0] cfg_index,
  input  wire  [SQUARE_W-1:0]    cfg_data
);

  logic [SQUARE_W-1:0] square_low;
  logic [SQUARE_W-1:0] square_mid;
  letter_t             square_last;
  square_t             square;

  logic    in_action;
  letter_t in_first;
  letter_t in_second;
  loc_t    lane_a;
  loc_t    lane_b;

  logic    s1_valid;
  logic    s1_action;
  loc_t    s1_loc_a;
  loc_t    s1_loc_b;
  logic    s1_ready;
  logic    s2_ready;

  letter_t mrg_first;
  letter_t mrg_second;
  logic    mrg_not_found;

  letter_t out_first;
  letter_t out_second;
  logic    out_not_found;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      square_low  <= SQUARE_LOW_RESET;
      square_mid  <= SQUARE_MID_RESET;
      square_last <= SQUARE_LAST_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_SQUARE_LOW:  square_low  <= cfg_data;
        REG_SQUARE_MID:  square_mid  <= cfg_data;
        REG_SQUARE_LAST: square_last <= cfg_data[LETTER_W-1:0];
        default: ;
      endcase
    end
  end

  // Cell 0 sits in the lowest bits.
  assign square = {square_last, square_mid, square_low};

  // Unpack the input transaction.
  assign in_action = s_axis_tuser;
  assign in_first  = s_axis_tdata[LETTER_W-1:0];
  assign in_second = s_axis_tdata[2*LETTER_W-1:LETTER_W];

  // One search lane per letter.
  pfc_locate u_lane_a (
    .letter (in_first),
    .square (square),
    .loc    (lane_a)
  );

  pfc_locate u_lane_b (
    .letter (in_second),
    .square (square),
    .loc    (lane_b)
  );

  // Stage handshake: each stage loads when empty or when it drains.
  assign s2_ready      = !m_axis_tvalid || m_axis_tready;
  assign s1_ready      = !s1_valid || s2_ready;
  assign s_axis_tready = s1_ready;

  // Lane result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s_axis_tvalid) begin
      s1_action <= in_action;
      s1_loc_a  <= lane_a;
      s1_loc_b  <= lane_b;
    end
  end

  // Combine both lanes into the cipher letters.
  pfc_merge u_merge (
    .loc_a      (s1_loc_a),
    .loc_b      (s1_loc_b),
    .action     (s1_action),
    .square     (square),
    .first_out  (mrg_first),
    .second_out (mrg_second),
    .not_found  (mrg_not_found)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s2_ready) begin
      m_axis_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      out_first     <= mrg_first;
      out_second    <= mrg_second;
      out_not_found <= mrg_not_found;
    end
  end

  assign m_axis_tdata = {
    (OUT_DATA_W - 2 * LETTER_W)'(0), out_second, out_first
  };
  assign m_axis_tuser = out_not_found;

endmodule

`default_nettype wire

### test/playfair_digraph_cipher_test.sv
// Self-checking testbench for the Playfair digraph cipher block.
// It predicts each enciphered or deciphered digraph from a shadow key square.
// Depends only on pfc_pkg and the playfair_digraph_cipher RTL.
`timescale 1ns / 1ps

module playfair_digraph_cipher_test;
  import pfc_pkg::*;

  // Expected content of one output transaction.
  typedef struct packed {
    logic    not_found;
    letter_t second_out;
    letter_t first_out;
  } digraph_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // first_letter[4:0], second_letter[9:5], zero fill above.
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
  // action.
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // first_out[4:0], second_out[9:5], zero fill above.
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  // not_found.
  logic                   m_axis_tuser;
  logic                   cfg_wen = 1'b0;
  logic [REG_INDEX_W-1:0] cfg_index = REG_SQUARE_LOW;
  logic [SQUARE_W-1:0]    cfg_data = '0;

  // Shadow copy of the key square registers.
  logic [SQUARE_W-1:0] key_low = SQUARE_LOW_RESET;
  logic [SQUARE_W-1:0] key_mid = SQUARE_MID_RESET;
  letter_t             key_last = SQUARE_LAST_RESET;

  digraph_result_t pending_results[$];
  bit idle_on = 1'b1;
  int fail_count = 0;
  int digraph_count = 0;
  int absent_count = 0;
  int reg_write_count = 0;

  playfair_digraph_cipher dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #1 clk = ~clk;

  // Letter held in cell k of the shadow square, row-major.
  function automatic letter_t key_cell(int k);
    if (k < 12) return key_low[5*k +: 5];
    if (k < 24) return key_mid[5*(k-12) +: 5];
    return key_last;
  endfunction

  // Lowest cell holding the letter after the J to I folding, or CELL_COUNT.
  function automatic int find_cell(letter_t code);
    letter_t probe;
    probe = (code == LETTER_J) ? LETTER_I : code;
    for (int k = 0; k < CELL_COUNT; k++) begin
      if (key_cell(k) == probe) return k;
    end
    return CELL_COUNT;
  endfunction

  // Playfair rules on the shadow square.
  function automatic digraph_result_t transform_digraph(logic act, letter_t a, letter_t b);
    digraph_result_t res;
    int pa, pb, r1, c1, r2, c2, shift;
    res = '0;
    pa = find_cell(a);
    pb = find_cell(b);
    if (pa >= CELL_COUNT || pb >= CELL_COUNT) begin
      res.not_found = 1'b1;
      return res;
    end
    r1 = pa / SIDE;
    c1 = pa % SIDE;
    r2 = pb / SIDE;
    c2 = pb % SIDE;
    // Moving back one position equals moving forward SIDE-1 positions.
    shift = (act == ACTION_DECRYPT) ? SIDE - 1 : 1;
    if (r1 == r2) begin
      res.first_out  = key_cell(r1 * SIDE + (c1 + shift) % SIDE);
      res.second_out = key_cell(r2 * SIDE + (c2 + shift) % SIDE);
    end else if (c1 == c2) begin
      res.first_out  = key_cell(((r1 + shift) % SIDE) * SIDE + c1);
      res.second_out = key_cell(((r2 + shift) % SIDE) * SIDE + c2);
    end else begin
      res.first_out  = key_cell(r1 * SIDE + c2);
      res.second_out = key_cell(r2 * SIDE + c1);
    end
    return res;
  endfunction

  // Send one digraph, optionally after an idle burst, and record its prediction.
  task automatic send_digraph(logic act, letter_t a, letter_t b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, b, a};
    s_axis_tuser  <= act;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_results.push_back(transform_digraph(act, a, b));
    digraph_count++;
  endtask

  // Stop sending and wait until every predicted result has been checked.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write the selected key square registers while the block is idle.
  task automatic load_square(logic [2:0] sel, logic [SQUARE_W-1:0] low,
                             logic [SQUARE_W-1:0] mid, letter_t last);
    wait_for_results();
    for (int r = 0; r < 3; r++) begin
      if (sel[r]) begin
        cfg_wen <= 1'b1;
        case (r)
          0: begin
            cfg_index <= REG_SQUARE_LOW;
            cfg_data  <= low;
          end
          1: begin
            cfg_index <= REG_SQUARE_MID;
            cfg_data  <= mid;
          end
          default: begin
            cfg_index <= REG_SQUARE_LAST;
            cfg_data  <= SQUARE_W'(last);
          end
        endcase
        @(posedge clk);
        case (r)
          0: key_low = low;
          1: key_mid = mid;
          default: key_last = last;
        endcase
        reg_write_count++;
      end
    end
    cfg_wen <= 1'b0;
  endtask

  // A well-formed square: the 25 letters other than J in random order.
  task automatic shuffled_square(output logic [SQUARE_W-1:0] low,
                                 output logic [SQUARE_W-1:0] mid, output letter_t last);
    letter_t pool[CELL_COUNT];
    letter_t tmp;
    int n, j;
    n = 0;
    for (int c = 0; c < 26; c++) begin
      if (letter_t'(c) != LETTER_J) begin
        pool[n] = letter_t'(c);
        n++;
      end
    end
    for (int i = CELL_COUNT - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = pool[i];
      pool[i] = pool[j];
      pool[j] = tmp;
    end
    for (int k = 0; k < 12; k++) begin
      low[5*k +: 5] = pool[k];
      mid[5*k +: 5] = pool[k + 12];
    end
    last = pool[24];
  endtask

  // Digraph biased toward shared rows and columns, with some absent and J letters.
  task automatic send_random_digraph();
    int k1, k2, mode;
    letter_t a, b, tmp;
    k1 = $urandom_range(0, CELL_COUNT - 1);
    mode = $urandom_range(0, 9);
    case (mode)
      0, 1, 2: k2 = (k1 / SIDE) * SIDE + $urandom_range(0, SIDE - 1);
      3, 4, 5: k2 = $urandom_range(0, SIDE - 1) * SIDE + k1 % SIDE;
      default: k2 = $urandom_range(0, CELL_COUNT - 1);
    endcase
    a = key_cell(k1);
    b = key_cell(k2);
    if (mode == 8) b = letter_t'($urandom_range(0, 31));
    if (mode == 9) a = $urandom_range(0, 1) ? LETTER_J : letter_t'($urandom_range(0, 31));
    if (a == LETTER_I && $urandom_range(0, 1)) a = LETTER_J;
    if ($urandom_range(0, 1)) begin
      tmp = a;
      a = b;
      b = tmp;
    end
    send_digraph(logic'($urandom_range(0, 1)), a, b);
  endtask

  // Every rule and edge case on the default square loaded at reset.
  task automatic test_reset_square();
    letter_t missing;
    missing = '1;
    for (int c = 0; c < 32; c++) begin
      if (find_cell(letter_t'(c)) == CELL_COUNT) missing = letter_t'(c);
    end
    send_digraph(ACTION_ENCRYPT, key_cell(0), key_cell(1));
    send_digraph(ACTION_DECRYPT, key_cell(0), key_cell(1));
    send_digraph(ACTION_ENCRYPT, key_cell(4), key_cell(2));
    send_digraph(ACTION_DECRYPT, key_cell(0), key_cell(3));
    send_digraph(ACTION_ENCRYPT, key_cell(20), key_cell(5));
    send_digraph(ACTION_DECRYPT, key_cell(0), key_cell(10));
    send_digraph(ACTION_ENCRYPT, key_cell(6), key_cell(18));
    send_digraph(ACTION_DECRYPT, key_cell(6), key_cell(18));
    // Same letter twice falls under the shared-row rule.
    send_digraph(ACTION_ENCRYPT, key_cell(12), key_cell(12));
    send_digraph(ACTION_DECRYPT, key_cell(24), key_cell(24));
    // J folds onto I before the search.
    send_digraph(ACTION_ENCRYPT, LETTER_J, key_cell(7));
    send_digraph(ACTION_ENCRYPT, LETTER_I, key_cell(7));
    send_digraph(ACTION_DECRYPT, key_cell(13), LETTER_J);
    send_digraph(ACTION_ENCRYPT, 5'd0, 5'd25);
    send_digraph(ACTION_DECRYPT, 5'd25, 5'd0);
    // Letters the square does not hold.
    send_digraph(ACTION_ENCRYPT, missing, key_cell(0));
    send_digraph(ACTION_DECRYPT, key_cell(0), missing);
    send_digraph(ACTION_ENCRYPT, 5'd31, 5'd31);
    send_digraph(ACTION_DECRYPT, 5'd26, 5'd30);
  endtask

  // Extreme, partial and malformed register settings.
  task automatic test_register_settings();
    logic [SQUARE_W-1:0] low, mid;
    letter_t last;
    // Every cell holds A, so every other letter is absent.
    load_square(3'b111, '0, '0, 5'd0);
    send_digraph(ACTION_ENCRYPT, 5'd0, 5'd0);
    send_digraph(ACTION_DECRYPT, 5'd0, LETTER_J);
    send_digraph(ACTION_ENCRYPT, 5'd1, 5'd0);
    repeat (12) send_random_digraph();
    // Every packed cell holds code 31, bottom right holds Z.
    load_square(3'b111, '1, '1, 5'd25);
    send_digraph(ACTION_ENCRYPT, 5'd31, 5'd25);
    send_digraph(ACTION_DECRYPT, 5'd25, 5'd31);
    send_digraph(ACTION_ENCRYPT, 5'd25, 5'd25);
    send_digraph(ACTION_DECRYPT, 5'd31, 5'd31);
    repeat (12) send_random_digraph();
    shuffled_square(low, mid, last);
    load_square(3'b111, low, mid, last);
    repeat (20) send_random_digraph();
    // Rewrite only the middle register: a stored J, code 30 and a repeated letter.
    mid[4:0]   = LETTER_J;
    mid[19:15] = 5'd30;
    mid[44:40] = key_cell(2);
    load_square(3'b010, low, mid, last);
    send_digraph(ACTION_ENCRYPT, LETTER_J, key_cell(0));
    send_digraph(ACTION_DECRYPT, 5'd30, key_cell(0));
    send_digraph(ACTION_ENCRYPT, key_cell(2), key_cell(24));
    send_digraph(ACTION_DECRYPT, key_cell(14), key_cell(11));
    repeat (15) send_random_digraph();
    // Rewrite only the bottom right cell.
    load_square(3'b100, low, mid, 5'd0);
    send_digraph(ACTION_ENCRYPT, key_cell(23), 5'd0);
    repeat (10) send_random_digraph();
  endtask

  // Long random traffic over several squares; the final phase runs without idling.
  task automatic test_random_traffic();
    logic [SQUARE_W-1:0] low, mid;
    logic [63:0] bits;
    letter_t last;
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 3) begin
        bits = {$urandom, $urandom};
        low = bits[SQUARE_W-1:0];
        bits = {$urandom, $urandom};
        mid = bits[SQUARE_W-1:0];
        last = letter_t'($urandom_range(0, 25));
      end else begin
        shuffled_square(low, mid, last);
      end
      load_square(3'b111, low, mid, last);
      idle_on = (phase != 5);
      for (int n = 0; n < 250; n++) begin
        // Let the pipeline empty once mid-stream.
        if (phase == 2 && n == 125) wait_for_results();
        send_random_digraph();
      end
    end
  endtask

  // Output side: random backpressure bursts while idling is enabled.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Compare each output transaction with the oldest prediction.
  always @(posedge clk) begin : result_check
    digraph_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected output transaction, tdata %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[4:0] !== want.first_out) begin
          $error("first_out: expected %0d, actual %0d", want.first_out, m_axis_tdata[4:0]);
          fail_count++;
        end
        if (m_axis_tdata[9:5] !== want.second_out) begin
          $error("second_out: expected %0d, actual %0d", want.second_out, m_axis_tdata[9:5]);
          fail_count++;
        end
        if (m_axis_tuser !== want.not_found) begin
          $error("not_found: expected %0d, actual %0d", want.not_found, m_axis_tuser);
          fail_count++;
        end
        if (want.not_found) absent_count++;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_square();
    test_register_settings();
    test_random_traffic();
    wait_for_results();
    repeat (10) @(posedge clk);
    $display("Checked %0d digraphs (%0d with an absent letter) across %0d register writes,",
             digraph_count, absent_count, reg_write_count);
    $display("with random gaps and backpressure on both streams before a final unstalled phase.");
    if (fail_count == 0) begin
      $display("playfair_digraph_cipher_test: PASS");
    end else begin
      $display("playfair_digraph_cipher_test: FAIL");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #1_000_000;
    $display("playfair_digraph_cipher_test: FAIL");
    $finish;
  end

endmodule
